FILE: hdl/dfr_pkg.sv
package dfr_pkg;

  // default frame length and register reset values
  localparam int unsigned FRAME_BYTES_DEF = 16;
  localparam logic [7:0]  WINDOW_RST      = 8'd20;
  localparam logic [15:0] STALE_RST       = 16'd2000;
  localparam logic [7:0]  OPEN_RST        = 8'h28;
  localparam logic [7:0]  CLOSE_RST       = 8'h29;
  localparam logic [7:0]  FILL_RST        = 8'hFF;

  // command queue between front and back
  localparam int unsigned Q_DEPTH = 2;

  // register file address and data widths
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  typedef enum logic [2:0] {
    REG_WINDOW = 3'd0,
    REG_STALE  = 3'd1,
    REG_OPEN   = 3'd2,
    REG_CLOSE  = 3'd3,
    REG_FILL   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [7:0]  window_ticks;
    logic [15:0] stale_ticks;
    logic [7:0]  open_char;
    logic [7:0]  close_char;
    logic [7:0]  fill_byte;
  } cfg_t;

  // one frame to send: stored payload from a bank, or a fill frame
  typedef struct packed {
    logic       fill;
    logic [7:0] fill_byte;
    logic       bank;
  } cmd_t;

  // payload bank handed back to the front
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

endpackage

FILE: hdl/dfr_queue.sv
module dfr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dfr_pkg::cmd_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output dfr_pkg::cmd_t head_o
);

  localparam int unsigned PTR_W = (dfr_pkg::Q_DEPTH > 1) ? $clog2(dfr_pkg::Q_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(dfr_pkg::Q_DEPTH + 1);

  dfr_pkg::cmd_t entry_q [dfr_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(dfr_pkg::Q_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(dfr_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(dfr_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/dfr_front.sv
module dfr_front #(
  parameter int unsigned FRAME_BYTES = dfr_pkg::FRAME_BYTES_DEF,
  localparam int unsigned CNT_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             func_i,
  input  logic [7:0]       rx_byte_i,
  input  dfr_pkg::cfg_t    cfg_i,
  input  logic             q_full_i,
  output logic             push_o,
  output dfr_pkg::cmd_t    push_cmd_o,
  output logic             wr_en_o,
  output logic [CNT_W:0]   wr_addr_o,
  output logic [7:0]       wr_data_o,
  input  dfr_pkg::rel_t    rel_i
);

  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_BYTES - 1);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_DATA,
    PH_CLOSE
  } phase_e;

  phase_e           phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       win_q, win_d, win_inc;
  logic [15:0]      stale_q, stale_d, stale_inc;
  logic             lost_q, lost_d;
  logic             wr_bank_q, wr_bank_d;
  logic [1:0]       busy_q, busy_d;
  logic             acc;

  // a bank still being read out by the back may not be overwritten
  assign in_ready_o = !q_full_i && !busy_q[wr_bank_q];
  assign acc        = in_valid_i && in_ready_o;
  assign wr_addr_o  = {wr_bank_q, cnt_q};
  assign wr_data_o  = rx_byte_i;

  assign win_inc   = (win_q == 8'hFF) ? win_q : win_q + 8'd1;
  assign stale_inc = (stale_q == 16'hFFFF) ? stale_q : stale_q + 16'd1;

  always_comb begin
    phase_d    = phase_q;
    cnt_d      = cnt_q;
    win_d      = win_q;
    stale_d    = stale_q;
    lost_d     = lost_q;
    wr_bank_d  = wr_bank_q;
    busy_d     = busy_q;
    push_o     = 1'b0;
    push_cmd_o = '0;
    wr_en_o    = 1'b0;

    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end

    if (acc) begin
      if (!func_i) begin
        unique case (phase_q)
          PH_HUNT: begin
            if (rx_byte_i == cfg_i.open_char) begin
              phase_d = PH_DATA;
              cnt_d   = '0;
              win_d   = '0;
            end
          end
          PH_DATA: begin
            wr_en_o = 1'b1;
            if (cnt_q == LAST_IDX) begin
              cnt_d   = '0;
              phase_d = PH_CLOSE;
            end else begin
              cnt_d = cnt_q + 1'b1;
            end
          end
          PH_CLOSE: begin
            phase_d = PH_HUNT;
            cnt_d   = '0;
            if (rx_byte_i == cfg_i.close_char) begin
              stale_d           = '0;
              lost_d            = 1'b0;
              push_o            = 1'b1;
              push_cmd_o.bank   = wr_bank_q;
              wr_bank_d         = ~wr_bank_q;
              busy_d[wr_bank_q] = 1'b1;
            end
          end
          default: begin
            phase_d = PH_HUNT;
          end
        endcase
      end else begin
        if (phase_q != PH_HUNT) begin
          win_d = win_inc;
          if (win_inc >= cfg_i.window_ticks) begin
            phase_d = PH_HUNT;
            cnt_d   = '0;
          end
        end
        stale_d = stale_inc;
        if (!lost_q && stale_inc >= cfg_i.stale_ticks) begin
          lost_d               = 1'b1;
          push_o               = 1'b1;
          push_cmd_o.fill      = 1'b1;
          push_cmd_o.fill_byte = cfg_i.fill_byte;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      cnt_q     <= '0;
      win_q     <= '0;
      stale_q   <= '0;
      lost_q    <= 1'b0;
      wr_bank_q <= 1'b0;
      busy_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      win_q     <= win_d;
      stale_q   <= stale_d;
      lost_q    <= lost_d;
      wr_bank_q <= wr_bank_d;
      busy_q    <= busy_d;
    end
  end

endmodule

FILE: hdl/dfr_back.sv
module dfr_back #(
  parameter int unsigned FRAME_BYTES = dfr_pkg::FRAME_BYTES_DEF,
  localparam int unsigned CNT_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_en_i,
  input  logic [CNT_W:0] wr_addr_i,
  input  logic [7:0]     wr_data_i,
  input  logic           q_empty_i,
  input  dfr_pkg::cmd_t  q_head_i,
  output logic           pop_o,
  output dfr_pkg::rel_t  rel_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           out_last_o,
  output logic           link_lost_o
);

  localparam int unsigned    MEM_DEPTH = 2 ** (CNT_W + 1);
  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_BYTES - 1);

  // two payload banks
  logic [7:0] mem [MEM_DEPTH];
  logic [7:0] rd_data_q;

  logic             active_q;
  dfr_pkg::cmd_t    cmd_q;
  logic [CNT_W-1:0] idx_q;

  // read stage
  logic       s1_v_q, s1_last_q, s1_fill_q;
  logic [7:0] s1_fb_q;

  // output register
  logic       out_v_q, out_last_q, out_lost_q;
  logic [7:0] out_byte_q;

  logic out_adv, s1_free, issue, last_issue;

  assign out_adv    = !out_v_q || out_ready_i;
  assign s1_free    = !s1_v_q || out_adv;
  assign issue      = active_q && s1_free;
  assign last_issue = issue && (idx_q == LAST_IDX);
  assign pop_o      = !active_q && !q_empty_i;

  // bank is free once its last byte has been read
  assign rel_o.valid = last_issue && !cmd_q.fill;
  assign rel_o.bank  = cmd_q.bank;

  assign out_valid_o = out_v_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign link_lost_o = out_lost_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (issue) begin
      rd_data_q <= mem[{cmd_q.bank, idx_q}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= q_head_i;
    end
    if (issue) begin
      s1_last_q <= (idx_q == LAST_IDX);
      s1_fill_q <= cmd_q.fill;
      s1_fb_q   <= cmd_q.fill_byte;
    end
    if (out_adv) begin
      out_byte_q <= s1_fill_q ? s1_fb_q : rd_data_q;
      out_last_q <= s1_last_q;
      out_lost_q <= s1_fill_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
      s1_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (pop_o) begin
        active_q <= 1'b1;
        idx_q    <= '0;
      end else if (issue) begin
        if (last_issue) begin
          active_q <= 1'b0;
          idx_q    <= '0;
        end else begin
          idx_q <= idx_q + 1'b1;
        end
      end
      if (s1_free) begin
        s1_v_q <= issue;
      end
      if (out_adv) begin
        out_v_q <= s1_v_q;
      end
    end
  end

endmodule

FILE: hdl/delimited_frame_receiver_top.sv
// delimited frame receiver: each input request is a received serial byte (func_i = 0) or a
// one millisecond tick (func_i = 1). the receiver hunts for open_char, stores exactly
// FRAME_BYTES payload bytes and then expects close_char; on a good close the frame is sent
// out as FRAME_BYTES output requests with out_last_o on the final byte. a wrong close or a
// frame still open after window_ticks ticks is dropped silently. if no good frame arrives
// for stale_ticks ticks, one frame of fill_byte values goes out with link_lost_o set, once
// per outage. an input request is taken every clock cycle while in_ready_o is high, and
// output bytes stream at one per cycle within a frame while out_ready_i is high, with a gap
// between frames; a frame's command passes the queue, command register, read stage and
// output register before its first byte leaves. in_ready_o drops only when two frames are
// already waiting, or when the next payload bank is not yet read out, so a burst of
// FRAME_BYTES outputs is absorbed between delimiters. configuration is a small apb register
// file (window, stale, open, close, fill at byte offsets 0x0 to 0x10), written while idle
module delimited_frame_receiver_top #(
  parameter int unsigned FRAME_BYTES = dfr_pkg::FRAME_BYTES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input requests
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        func_i,
  input  logic [7:0]                  rx_byte_i,
  // output requests
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  out_byte_o,
  output logic                        out_last_o,
  output logic                        link_lost_o,
  // apb register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dfr_pkg::PADDR_W-1:0] paddr,
  input  logic [dfr_pkg::PDATA_W-1:0] pwdata,
  output logic [dfr_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int unsigned CNT_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

  // ---------------------------------------------------------------------------
  // register file
  // ---------------------------------------------------------------------------
  dfr_pkg::cfg_t    cfg_q;
  dfr_pkg::reg_idx_e reg_idx;
  logic             cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = dfr_pkg::reg_idx_e'(paddr[dfr_pkg::PADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_ticks <= dfr_pkg::WINDOW_RST;
      cfg_q.stale_ticks  <= dfr_pkg::STALE_RST;
      cfg_q.open_char    <= dfr_pkg::OPEN_RST;
      cfg_q.close_char   <= dfr_pkg::CLOSE_RST;
      cfg_q.fill_byte    <= dfr_pkg::FILL_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        dfr_pkg::REG_WINDOW: cfg_q.window_ticks <= pwdata[7:0];
        dfr_pkg::REG_STALE:  cfg_q.stale_ticks  <= pwdata[15:0];
        dfr_pkg::REG_OPEN:   cfg_q.open_char    <= pwdata[7:0];
        dfr_pkg::REG_CLOSE:  cfg_q.close_char   <= pwdata[7:0];
        dfr_pkg::REG_FILL:   cfg_q.fill_byte    <= pwdata[7:0];
        default: begin
          // addresses past the register list are ignored
        end
      endcase
    end
  end

  // read back, zero extended
  always_comb begin
    unique case (reg_idx)
      dfr_pkg::REG_WINDOW: prdata = dfr_pkg::PDATA_W'(cfg_q.window_ticks);
      dfr_pkg::REG_STALE:  prdata = dfr_pkg::PDATA_W'(cfg_q.stale_ticks);
      dfr_pkg::REG_OPEN:   prdata = dfr_pkg::PDATA_W'(cfg_q.open_char);
      dfr_pkg::REG_CLOSE:  prdata = dfr_pkg::PDATA_W'(cfg_q.close_char);
      dfr_pkg::REG_FILL:   prdata = dfr_pkg::PDATA_W'(cfg_q.fill_byte);
      default:             prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // front: delimiter hunt, payload capture, window and staleness timers
  // ---------------------------------------------------------------------------
  logic             q_full, q_empty, push, pop;
  dfr_pkg::cmd_t    push_cmd, q_head;
  dfr_pkg::rel_t    rel;
  logic             wr_en;
  logic [CNT_W:0]   wr_addr;
  logic [7:0]       wr_data;

  dfr_front #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .rx_byte_i  (rx_byte_i),
    .cfg_i      (cfg_q),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_cmd_o (push_cmd),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rel_i      (rel)
  );

  // ---------------------------------------------------------------------------
  // frame command queue: good frames (with their bank) and fill frames
  // ---------------------------------------------------------------------------
  dfr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  // ---------------------------------------------------------------------------
  // back: payload banks and byte streaming
  // ---------------------------------------------------------------------------
  dfr_back #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .pop_o       (pop),
    .rel_o       (rel),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o),
    .link_lost_o (link_lost_o)
  );

endmodule

FILE: hdl/dfr_checker.sv
module dfr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       out_last_o,
  input logic       link_lost_o
);

  logic out_acc;
  assign out_acc = out_valid_o && out_ready_i;

  // nothing is offered right after reset has been seen
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

  // stalled output holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(out_last_o) && $stable(link_lost_o))
    else $error("stalled output changed");

  // a frame streams without gaps once started
  a_burst_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !out_last_o |=> out_valid_o)
    else $error("gap inside a frame");

  // fill flag is the same on every byte of a frame
  a_lost_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !out_last_o |=> link_lost_o == $past(link_lost_o))
    else $error("link lost flag changed inside a frame");

endmodule

bind delimited_frame_receiver_top dfr_checker u_dfr_checker (.*);

FILE: verif/tb_delimited_frame_receiver_top.sv
`timescale 1ns / 1ps

module tb_delimited_frame_receiver_top;

  localparam int unsigned FRAME_BYTES   = dfr_pkg::FRAME_BYTES_DEF;
  // request kinds on func_i
  localparam logic        FUNC_BYTE     = 1'b0;
  localparam logic        FUNC_TICK     = 1'b1;
  // first address past the register file, writes there must be ignored
  localparam logic [dfr_pkg::PADDR_W-1:0] UNMAPPED_ADDR = {3'd5, 2'b00};
  // ample for the registers between the closing request and the first output byte
  localparam int unsigned SETTLE_CYCLES = 12;
  // long output stall, far longer than two queued frames take to back up the input
  localparam int unsigned HOLD_CYCLES   = 400;

  typedef enum logic [1:0] {
    HUNT,
    COLLECT,
    AWAIT_CLOSE
  } rx_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       lost;
  } out_beat_t;

  // tracks the deframer state and keeps the output bytes it must produce, in order
  class frame_tracker;
    logic [7:0]  window_ticks = dfr_pkg::WINDOW_RST;
    logic [15:0] stale_ticks  = dfr_pkg::STALE_RST;
    logic [7:0]  open_char    = dfr_pkg::OPEN_RST;
    logic [7:0]  close_char   = dfr_pkg::CLOSE_RST;
    logic [7:0]  fill_byte    = dfr_pkg::FILL_RST;

    rx_phase_e   phase        = HUNT;
    int unsigned count        = 0;
    logic [7:0]  payload [FRAME_BYTES];
    logic [7:0]  window_cnt   = '0;
    logic [15:0] stale_cnt    = '0;
    logic        lost_flag    = 1'b0;

    out_beat_t   due_bytes [$];
    int unsigned fail_count   = 0;

    function void write_reg(logic [dfr_pkg::PADDR_W-1:0] addr, logic [31:0] data);
      case (addr[dfr_pkg::PADDR_W-1:2])
        dfr_pkg::REG_WINDOW: window_ticks = data[7:0];
        dfr_pkg::REG_STALE:  stale_ticks  = data[15:0];
        dfr_pkg::REG_OPEN:   open_char    = data[7:0];
        dfr_pkg::REG_CLOSE:  close_char   = data[7:0];
        dfr_pkg::REG_FILL:   fill_byte    = data[7:0];
        default: ;
      endcase
    endfunction

    function void emit_frame(logic fill_mode);
      out_beat_t beat;
      for (int k = 0; k < FRAME_BYTES; k++) begin
        beat.data = fill_mode ? fill_byte : payload[k];
        beat.last = (k == FRAME_BYTES - 1);
        beat.lost = fill_mode;
        due_bytes.push_back(beat);
      end
    endfunction

    function void take_request(logic func, logic [7:0] data);
      if (func == FUNC_BYTE) begin
        case (phase)
          HUNT: begin
            if (data == open_char) begin
              phase      = COLLECT;
              count      = 0;
              window_cnt = '0;
            end
          end
          COLLECT: begin
            payload[count] = data;
            if (count == FRAME_BYTES - 1) begin
              count = 0;
              phase = AWAIT_CLOSE;
            end else begin
              count++;
            end
          end
          default: begin
            // any byte ends the frame, only the close delimiter makes it good
            phase = HUNT;
            count = 0;
            if (data == close_char) begin
              stale_cnt = '0;
              lost_flag = 1'b0;
              emit_frame(1'b0);
            end
          end
        endcase
      end else begin
        if (phase != HUNT) begin
          if (window_cnt != 8'hFF) window_cnt++;
          if (window_cnt >= window_ticks) begin
            phase = HUNT;
            count = 0;
          end
        end
        if (stale_cnt != 16'hFFFF) stale_cnt++;
        if (!lost_flag && stale_cnt >= stale_ticks) begin
          lost_flag = 1'b1;
          emit_frame(1'b1);
        end
      end
    endfunction

    function void match_byte(logic [7:0] data, logic last, logic lost);
      out_beat_t want;
      if (due_bytes.size() == 0) begin
        $display("%0t: output byte with none expected, expected none, got %02h last %0b lost %0b",
                 $time, data, last, lost);
        fail_count++;
        return;
      end
      want = due_bytes.pop_front();
      if (data !== want.data) begin
        $display("%0t: out_byte expected %02h, got %02h", $time, want.data, data);
        fail_count++;
      end
      if (last !== want.last) begin
        $display("%0t: out_last expected %0b, got %0b", $time, want.last, last);
        fail_count++;
      end
      if (lost !== want.lost) begin
        $display("%0t: link_lost expected %0b, got %0b", $time, want.lost, lost);
        fail_count++;
      end
    endfunction
  endclass

  logic                        clk;
  logic                        rst_n     = 1'b0;
  logic                        in_valid  = 1'b0;
  logic                        in_ready;
  logic                        func      = FUNC_BYTE;
  logic [7:0]                  rx_byte   = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [7:0]                  out_byte;
  logic                        out_last;
  logic                        link_lost;
  logic                        psel      = 1'b0;
  logic                        penable   = 1'b0;
  logic                        pwrite    = 1'b0;
  logic [dfr_pkg::PADDR_W-1:0] paddr     = '0;
  logic [dfr_pkg::PDATA_W-1:0] pwdata    = '0;
  logic [dfr_pkg::PDATA_W-1:0] prdata;
  logic                        pready;

  frame_tracker tracker = new();

  // sender burst state and the long receiver stall request
  int unsigned burst_left = 0;
  int unsigned req_count  = 0;
  bit          gaps_on    = 1'b1;
  bit          hold_rx    = 1'b0;

  delimited_frame_receiver_top #(
    .FRAME_BYTES(FRAME_BYTES)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .func_i      (func),
    .rx_byte_i   (rx_byte),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_byte_o  (out_byte),
    .out_last_o  (out_last),
    .link_lost_o (link_lost),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // output side: switches between always ready, coin flip and sparse ready,
  // and serves one long stall when the stimulus asks for it
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    mode      = 0;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (hold_rx) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_rx = 1'b0;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(8, 60);
      end
      mode_left--;
      case (mode)
        0: out_ready = 1'b1;
        1: out_ready = 1'($urandom_range(0, 1));
        default: out_ready = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // every accepted output request is matched against the oldest due byte
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.match_byte(out_byte, out_last, link_lost);
  end

  function automatic logic [dfr_pkg::PADDR_W-1:0] reg_addr(input dfr_pkg::reg_idx_e idx);
    return {idx, 2'b00};
  endfunction

  // apb write: setup cycle, then access cycle held until pready
  task automatic apb_write(input logic [dfr_pkg::PADDR_W-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tracker.write_reg(addr, data);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_config(input logic [7:0] window, input logic [15:0] stale,
                            input logic [7:0] open_c, input logic [7:0] close_c,
                            input logic [7:0] fill);
    apb_write(reg_addr(dfr_pkg::REG_WINDOW), {24'd0, window});
    apb_write(reg_addr(dfr_pkg::REG_STALE), {16'd0, stale});
    apb_write(reg_addr(dfr_pkg::REG_OPEN), {24'd0, open_c});
    apb_write(reg_addr(dfr_pkg::REG_CLOSE), {24'd0, close_c});
    apb_write(reg_addr(dfr_pkg::REG_FILL), {24'd0, fill});
  endtask

  // one input request; valid stays up across a burst, gaps fall between bursts
  task automatic send_req(input logic f, input logic [7:0] b);
    int unsigned gap;
    gap = 0;
    if (gaps_on && burst_left == 0) begin
      gap        = $urandom_range(0, 6);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left != 0) burst_left--;
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    func     = f;
    rx_byte  = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.take_request(f, b);
    req_count++;
  endtask

  // stop sending and wait until every due byte has come out, then let the block settle
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.due_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly random data, now and then a delimiter value landing inside the payload
  function automatic logic [7:0] payload_byte();
    case ($urandom_range(0, 19))
      0: return tracker.open_char;
      1: return tracker.close_char;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // full frame with random payload, good or wrong close, ticks sprinkled in
  task automatic send_frame(input bit good, input int unsigned tick_pct);
    logic [7:0] tail;
    send_req(FUNC_BYTE, tracker.open_char);
    for (int k = 0; k < FRAME_BYTES; k++) begin
      if ($urandom_range(1, 100) <= tick_pct) send_req(FUNC_TICK, 8'($urandom_range(0, 255)));
      send_req(FUNC_BYTE, payload_byte());
    end
    tail = good ? tracker.close_char : tracker.close_char ^ 8'($urandom_range(1, 255));
    send_req(FUNC_BYTE, tail);
  endtask

  // mostly well formed frames, plus wrong closes, cut off frames and loose noise
  task automatic random_traffic(input int unsigned n_req, input int unsigned tick_pct);
    int unsigned start;
    int unsigned pick;
    start = req_count;
    while (req_count - start < n_req) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_frame(1'b1, tick_pct);
      end else if (pick < 70) begin
        send_frame(1'b0, tick_pct);
      end else if (pick < 80) begin
        send_req(FUNC_BYTE, tracker.open_char);
        repeat ($urandom_range(1, 12)) send_req(FUNC_BYTE, payload_byte());
        repeat ($urandom_range(1, 6)) send_req(FUNC_TICK, 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 4)) send_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // short window and staleness so the directed requests reach both quickly
    set_config(8'd2, 16'd2, dfr_pkg::OPEN_RST, dfr_pkg::CLOSE_RST, dfr_pkg::FILL_RST);
    send_req(FUNC_TICK, 8'h00);
    send_req(FUNC_BYTE, 8'h00);               // not a delimiter while hunting
    send_req(FUNC_TICK, 8'hFF);               // link goes stale, fill frame
    send_req(FUNC_BYTE, tracker.open_char);
    send_req(FUNC_BYTE, 8'h00);
    send_req(FUNC_BYTE, 8'hFF);
    send_req(FUNC_BYTE, tracker.open_char);   // open delimiter inside payload is data
    send_req(FUNC_BYTE, tracker.close_char);  // so is the close delimiter
    repeat (FRAME_BYTES - 4) send_req(FUNC_BYTE, 8'($urandom_range(0, 255)));
    send_req(FUNC_BYTE, tracker.close_char);  // good close clears staleness
    send_req(FUNC_BYTE, tracker.open_char);
    send_req(FUNC_BYTE, 8'hA5);
    send_req(FUNC_TICK, 8'h5A);
    send_req(FUNC_TICK, 8'h00);               // window runs out and link goes stale together
    drain();

    // low extremes: one tick window, one tick staleness, delimiters at the byte edges
    set_config(8'd1, 16'd1, 8'h00, 8'hFF, 8'h00);
    send_frame(1'b0, 10);
    drain();

    // high extremes; output stalls long while good frames keep coming, so the
    // input side has to back up
    set_config(8'd255, 16'hFFFF, 8'hFF, 8'h00, 8'($urandom_range(0, 255)));
    apb_write(UNMAPPED_ADDR, 32'($urandom));
    gaps_on = 1'b0;
    hold_rx = 1'b1;
    repeat (3) send_frame(1'b1, 0);
    gaps_on = 1'b1;
    drain();

    // random settings with frequent ticks: expiries, fill frames and good frames mix
    set_config(8'($urandom_range(2, 6)), 16'($urandom_range(4, 30)),
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)));
    random_traffic(12, 8);
    drain();

    if (tracker.fail_count == 0) begin
      $display("delimited_frame_receiver_top test passed");
    end else begin
      $display("delimited_frame_receiver_top test failed");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #2_000_000;
    $display("delimited_frame_receiver_top test failed");
    $finish;
  end

endmodule
